[hw/rtl/hfa_pkg.sv]
// hfa_pkg: types, codes and defaults shared by the hole fit allocator.
// No dependencies; every other file imports it.
package hfa_pkg;

    localparam int HOLES_DEF     = 16;
    localparam int SIZE_BITS_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 4;
    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;
    localparam int POLICY_W = 2;
    localparam int COUNT_W  = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] HOLE_COUNT_RST = 5'd16;

    // register select is paddr[2]
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_NOFIT = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_SAT   = 2'd3
    } status_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_NEXT  = 2'd1,
        POL_BEST  = 2'd2,
        POL_WORST = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_LOAD,
        S_READ,
        S_RMW,
        S_RESP
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic ge;   // a >= b
        logic lt;   // a <  c
        logic gt;   // a >  c
    } alu_flags_t;

endpackage

[hw/rtl/hfa_if.sv]
// hfa_cmd_if / hfa_rsp_if: valid/ready channels for command and response words.
// Depends on hfa_pkg for field widths.
interface hfa_cmd_if import hfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  hole_index;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, action, hole_index, amount, input ready);
    modport sink   (input valid, action, hole_index, amount, output ready);
endinterface

interface hfa_rsp_if import hfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  chosen_hole;
    logic [AMOUNT_W-1:0] hole_left;

    modport source (output valid, status, chosen_hole, hole_left, input ready);
    modport sink   (input valid, status, chosen_hole, hole_left, output ready);
endinterface

[hw/rtl/hfa_alu.sv]
// hfa_alu: shared add/subtract and compare unit used by the scan, update, load and read-modify-write steps.
// Depends on hfa_pkg for the op code and flag struct.
module hfa_alu import hfa_pkg::*; #(
    parameter int W = 17
) (
    input  alu_op_t     op,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    output logic [W-1:0] res,
    output alu_flags_t   flags
);

    always_comb
    begin
        case (op)
            ALU_ADD: res = a + b;
            ALU_SUB: res = a - b;
            default: res = a + b;
        endcase
        flags.ge = (a >= b);
        flags.lt = (a < c);
        flags.gt = (a > c);
    end

endmodule

[hw/rtl/hfa_table.sv]
// hfa_table: hole size memory, one write and one registered read port.
// Per-entry valid bits make the whole table read as zero right after reset.
module hfa_table import hfa_pkg::*; #(
    parameter int HOLES     = HOLES_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    localparam int IDX_W    = (HOLES > 1) ? $clog2(HOLES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [SIZE_BITS-1:0] wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [SIZE_BITS-1:0] rd_data
);

    logic [SIZE_BITS-1:0] mem [HOLES];
    logic [HOLES-1:0]     vld_reg;
    logic [HOLES-1:0]     vld_next;
    logic [SIZE_BITS-1:0] rd_mem_reg;
    logic                 rd_vld_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_mem_reg : '0;

endmodule

[hw/rtl/hole_fit_allocator_core.sv]
// hole_fit_allocator_core: one command word at a time; ready only when idle.
// Load goes through S_LOAD, release through S_READ and S_RMW; a word rejected at accept
// (zero request, index out of range, unknown action) goes straight to S_RESP. Allocate
// scans to a first/next hit, or all n entries for best/worst or no fit (n = entries in use).
// No new word until the last is done; one table entry is read and compared per cycle.
// Reset: async active low; table reads as zero at once, rover 0, first fit, 16 holes.
module hole_fit_allocator_core import hfa_pkg::*; #(
    parameter int HOLES     = HOLES_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    hfa_cmd_if.sink            cmd,
    hfa_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W = $clog2(HOLES + 1);
    localparam int CMP_W = ((SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W) + 1;
    localparam logic [SIZE_BITS-1:0] HOLE_FULL = '1;
    localparam logic [CMP_W-1:0]     MAX_EXT   = CMP_W'(HOLE_FULL);

    // config
    policy_t              policy_reg, policy_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]     n_used;

    // sequencer
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     rover_reg, rover_next;
    logic [IDX_W-1:0]     iss_ptr_reg, iss_ptr_next;
    logic [CNT_W-1:0]     iss_cnt_reg, iss_cnt_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] best_reg, best_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [AMOUNT_W-1:0]  amt_reg, amt_next;
    status_t              res_status_reg, res_status_next;
    logic [INDEX_W-1:0]   res_hole_reg, res_hole_next;
    logic [AMOUNT_W-1:0]  res_left_reg, res_left_next;

    // output word
    logic                 out_vld_reg, out_vld_next;
    status_t              out_status_reg, out_status_next;
    logic [INDEX_W-1:0]   out_hole_reg, out_hole_next;
    logic [AMOUNT_W-1:0]  out_left_reg, out_left_next;
    logic                 out_load;

    // shared unit and table
    alu_op_t              alu_op;
    logic [CMP_W-1:0]     alu_a, alu_b, alu_c, alu_res;
    alu_flags_t           alu_flags;
    logic                 tbl_wr_en;
    logic [IDX_W-1:0]     tbl_wr_addr;
    logic [SIZE_BITS-1:0] tbl_wr_data;
    logic [IDX_W-1:0]     tbl_rd_addr;
    logic [SIZE_BITS-1:0] tbl_rd_data;

    logic                 hit;
    logic                 issue;
    logic                 idx_ok;
    logic                 sat;
    logic [SIZE_BITS-1:0] new_size;

    hfa_alu #(
        .W (CMP_W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .res   (alu_res),
        .flags (alu_flags)
    );

    hfa_table #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign n_used = (int'(count_reg) > HOLES) ? CNT_W'(HOLES) : CNT_W'(count_reg);

    always_comb
    begin
        policy_next = policy_reg;
        count_next  = count_reg;
        if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_POLICY: policy_next = policy_t'(pwdata[POLICY_W-1:0]);
                REG_COUNT:  count_next  = pwdata[COUNT_W-1:0];
                default:    policy_next = policy_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_POLICY: prdata = PDATA_W'(policy_reg);
            REG_COUNT:  prdata = PDATA_W'(count_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.chosen_hole = out_hole_reg;
    assign rsp.hole_left   = out_left_reg;

    assign idx_ok = (int'(cmd.hole_index) < int'(n_used));
    assign sat    = |alu_res[CMP_W-1:SIZE_BITS];

    always_comb
    begin
        state_next      = state_reg;
        rover_next      = rover_reg;
        iss_ptr_next    = iss_ptr_reg;
        iss_cnt_next    = iss_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        idx_next        = idx_reg;
        amt_next        = amt_reg;
        res_status_next = res_status_reg;
        res_hole_next   = res_hole_reg;
        res_left_next   = res_left_reg;
        out_load        = 1'b0;
        alu_op          = ALU_ADD;
        alu_a           = '0;
        alu_b           = '0;
        alu_c           = '0;
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = IDX_W'(idx_reg);
        tbl_wr_data     = '0;
        tbl_rd_addr     = IDX_W'(idx_reg);
        hit             = 1'b0;
        issue           = 1'b0;
        new_size        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    idx_next        = cmd.hole_index;
                    amt_next        = cmd.amount;
                    res_status_next = STAT_OK;
                    res_hole_next   = '0;
                    res_left_next   = '0;
                    case (action_t'(cmd.action))
                        ACT_LOAD:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_LOAD;
                            end
                            else
                            begin
                                res_status_next = STAT_RANGE;
                                state_next      = S_RESP;
                            end
                        end
                        ACT_RELEASE:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_status_next = STAT_RANGE;
                                state_next      = S_RESP;
                            end
                        end
                        ACT_ALLOC:
                        begin
                            if (cmd.amount == '0)
                            begin
                                res_status_next = STAT_NOFIT;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                iss_ptr_next = (policy_reg == POL_NEXT &&
                                                int'(rover_reg) < int'(n_used)) ?
                                               rover_reg : '0;
                                iss_cnt_next = '0;
                                found_next   = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_NOFIT;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                alu_a = CMP_W'(tbl_rd_data);
                alu_b = CMP_W'(amt_reg);
                alu_c = CMP_W'(best_reg);
                if (chk_vld_reg && alu_flags.ge)
                begin
                    case (policy_reg)
                        POL_FIRST, POL_NEXT:
                        begin
                            hit        = 1'b1;
                            found_next = 1'b1;
                            pick_next  = chk_idx_reg;
                            best_next  = tbl_rd_data;
                        end
                        POL_BEST:
                        begin
                            if (!found_reg || alu_flags.lt)
                            begin
                                found_next = 1'b1;
                                pick_next  = chk_idx_reg;
                                best_next  = tbl_rd_data;
                            end
                        end
                        POL_WORST:
                        begin
                            if (!found_reg || alu_flags.gt)
                            begin
                                found_next = 1'b1;
                                pick_next  = chk_idx_reg;
                                best_next  = tbl_rd_data;
                            end
                        end
                        default:
                        begin
                            hit = 1'b0;
                        end
                    endcase
                end
                issue        = (int'(iss_cnt_reg) < int'(n_used)) && !hit;
                tbl_rd_addr  = iss_ptr_reg;
                chk_vld_next = issue;
                chk_idx_next = iss_ptr_reg;
                if (issue)
                begin
                    iss_cnt_next = iss_cnt_reg + CNT_W'(1);
                    iss_ptr_next = (int'(iss_ptr_reg) + 1 >= int'(n_used)) ?
                                   '0 : iss_ptr_reg + IDX_W'(1);
                end
                if (hit)
                begin
                    state_next = S_UPDATE;
                end
                else if (!issue && !chk_vld_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        res_status_next = STAT_NOFIT;
                        state_next      = S_RESP;
                    end
                end
            end

            S_UPDATE:
            begin
                alu_op          = ALU_SUB;
                alu_a           = CMP_W'(best_reg);
                alu_b           = CMP_W'(amt_reg);
                tbl_wr_en       = 1'b1;
                tbl_wr_addr     = pick_reg;
                tbl_wr_data     = SIZE_BITS'(alu_res);
                rover_next      = pick_reg;
                res_status_next = STAT_OK;
                res_hole_next   = INDEX_W'(pick_reg);
                res_left_next   = AMOUNT_W'(alu_res);
                state_next      = S_RESP;
            end

            S_LOAD:
            begin
                alu_a         = CMP_W'(amt_reg);
                alu_c         = MAX_EXT;
                new_size      = alu_flags.gt ? HOLE_FULL : SIZE_BITS'(alu_res);
                tbl_wr_en     = 1'b1;
                tbl_wr_data   = new_size;
                res_hole_next = idx_reg;
                res_left_next = AMOUNT_W'(new_size);
                state_next    = S_RESP;
            end

            S_READ:
            begin
                state_next = S_RMW;
            end

            S_RMW:
            begin
                alu_a       = CMP_W'(tbl_rd_data);
                alu_b       = CMP_W'(amt_reg);
                new_size    = sat ? HOLE_FULL : SIZE_BITS'(alu_res);
                tbl_wr_en   = 1'b1;
                tbl_wr_data = new_size;
                if (sat)
                begin
                    res_status_next = STAT_SAT;
                    res_hole_next   = '0;
                end
                else
                begin
                    res_status_next = STAT_OK;
                    res_hole_next   = idx_reg;
                end
                res_left_next = AMOUNT_W'(new_size);
                state_next    = S_RESP;
            end

            S_RESP:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_vld_next    = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_reg);
        out_status_next = out_load ? res_status_reg : out_status_reg;
        out_hole_next   = out_load ? res_hole_reg : out_hole_reg;
        out_left_next   = out_load ? res_left_reg : out_left_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_FIRST;
            count_reg   <= HOLE_COUNT_RST;
            state_reg   <= S_IDLE;
            rover_reg   <= '0;
            iss_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            policy_reg  <= policy_next;
            count_reg   <= count_next;
            state_reg   <= state_next;
            rover_reg   <= rover_next;
            iss_cnt_reg <= iss_cnt_next;
            chk_vld_reg <= chk_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_ptr_reg    <= iss_ptr_next;
        chk_idx_reg    <= chk_idx_next;
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        idx_reg        <= idx_next;
        amt_reg        <= amt_next;
        res_status_reg <= res_status_next;
        res_hole_reg   <= res_hole_next;
        res_left_reg   <= res_left_next;
        out_status_reg <= out_status_next;
        out_hole_reg   <= out_hole_next;
        out_left_reg   <= out_left_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("command accepted while a word is in progress");

    a_fail_no_hole: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != STAT_OK |-> rsp.chosen_hole == '0)
        else $error("chosen_hole nonzero on a failed word");

    a_fail_no_left: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == STAT_NOFIT || rsp.status == STAT_RANGE)
        |-> rsp.hole_left == '0)
        else $error("hole_left nonzero on a rejected word");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |-> (state_reg == S_UPDATE || state_reg == S_LOAD ||
                       state_reg == S_RMW))
        else $error("table written outside an update step");
`endif

endmodule
